// File: hw/rtl/eight_bit_cpu_alu_with_flags_unit_macros.svh
// Assertion macros for the ALU block. Each expects clk and rst_n in scope.
`ifndef EIGHT_BIT_CPU_ALU_WITH_FLAGS_UNIT_MACROS_SVH
`define EIGHT_BIT_CPU_ALU_WITH_FLAGS_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define EBCALU_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("ebcalu: same-cycle check failed");
`define EBCALU_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("ebcalu: next-cycle check failed");
`else
`define EBCALU_ASSERT_IMP(lbl, pre, post)
`define EBCALU_ASSERT_NXT(lbl, pre, post)
`endif

`endif

// File: hw/rtl/ebcalu_pkg.sv
package ebcalu_pkg;

  localparam int KIND_W  = 5;
  localparam int WORD_W  = 16;
  localparam int BYTE_W  = 8;
  localparam int FLAGS_W = 4;

  // flag bit positions
  localparam int FLAG_Z = 3;
  localparam int FLAG_N = 2;
  localparam int FLAG_H = 1;
  localparam int FLAG_C = 0;

  typedef enum logic [KIND_W-1:0] {
    OP_ADD       = 5'd0,
    OP_ADC       = 5'd1,
    OP_SUB       = 5'd2,
    OP_CP        = 5'd3,
    OP_AND       = 5'd4,
    OP_OR        = 5'd5,
    OP_XOR       = 5'd6,
    OP_INC       = 5'd7,
    OP_DEC       = 5'd8,
    OP_CPL       = 5'd9,
    OP_CCF       = 5'd10,
    OP_RRA       = 5'd11,
    OP_RR        = 5'd12,
    OP_SRL       = 5'd13,
    OP_SWAP      = 5'd14,
    OP_ADD16     = 5'd15,
    OP_ADD_SP_E8 = 5'd16,
    OP_INC16     = 5'd17,
    OP_DEC16     = 5'd18
  } alu_op_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [WORD_W-1:0]  a;
    logic [WORD_W-1:0]  b;
    logic [FLAGS_W-1:0] flags;
  } alu_req_t;

  typedef struct packed {
    logic [WORD_W-1:0]  result;
    logic [FLAGS_W-1:0] flags;
  } alu_rsp_t;

  // per-stage handshake between neighbors
  typedef struct packed {
    logic valid;
    logic stall;
  } stage_hs_t;

endpackage

// File: hw/rtl/ebcalu_in_stage.sv
module ebcalu_in_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  output logic                 up_stall,
  input  ebcalu_pkg::alu_req_t up_req,
  input  logic                 dn_stall,
  output logic                 dn_valid,
  output ebcalu_pkg::alu_req_t dn_req
);
  import ebcalu_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  alu_req_t req_r;
  logic     load;

  // slot frees up when empty or when its item moves on this cycle
  assign up_stall  = valid_r && dn_stall;
  assign load      = up_valid && !up_stall;
  assign valid_nxt = load || (valid_r && dn_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      req_r <= up_req;
    end
  end

  assign dn_valid = valid_r;
  assign dn_req   = req_r;

endmodule

// File: hw/rtl/ebcalu_core.sv
module ebcalu_core (
  input  ebcalu_pkg::alu_req_t req,
  output ebcalu_pkg::alu_rsp_t rsp
);
  import ebcalu_pkg::*;

  logic [BYTE_W-1:0]   a8;
  logic [BYTE_W-1:0]   b8;
  logic                cin;
  logic                add_cin;
  logic [BYTE_W:0]     sum8;
  logic [4:0]          sum4;
  logic [BYTE_W:0]     dif8;
  logic [4:0]          dif4;
  logic [WORD_W:0]     sum16;
  logic [12:0]         sum12;
  logic [BYTE_W-1:0]   r8;
  logic [WORD_W-1:0]   r16;
  logic [FLAGS_W-1:0]  nf;
  logic                use8;

  assign a8  = req.a[BYTE_W-1:0];
  assign b8  = req.b[BYTE_W-1:0];
  assign cin = req.flags[FLAG_C];

  // shared 8-bit adder: adc adds carry, add and add_sp_e8 do not
  assign add_cin = (alu_op_t'(req.kind) == OP_ADC) ? cin : 1'b0;
  assign sum8  = {1'b0, a8} + {1'b0, b8} + {{BYTE_W{1'b0}}, add_cin};
  assign sum4  = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'b0, add_cin};
  assign dif8  = {1'b0, a8} - {1'b0, b8};
  assign dif4  = {1'b0, a8[3:0]} - {1'b0, b8[3:0]};
  assign sum16 = {1'b0, req.a} + {1'b0, req.b};
  assign sum12 = {1'b0, req.a[11:0]} + {1'b0, req.b[11:0]};

  always_comb begin
    r8   = '0;
    r16  = req.a;
    nf   = req.flags;
    use8 = 1'b1;
    case (alu_op_t'(req.kind))
      OP_ADD, OP_ADC: begin
        r8 = sum8[BYTE_W-1:0];
        nf = {r8 == '0, 1'b0, sum4[4], sum8[BYTE_W]};
      end
      OP_SUB, OP_CP: begin
        r8 = dif8[BYTE_W-1:0];
        nf = {r8 == '0, 1'b1, dif4[4], dif8[BYTE_W]};
        // compare keeps the full operand
        use8 = (alu_op_t'(req.kind) == OP_SUB);
      end
      OP_AND: begin
        r8 = a8 & b8;
        nf = {r8 == '0, 1'b0, 1'b1, 1'b0};
      end
      OP_OR: begin
        r8 = a8 | b8;
        nf = {r8 == '0, 3'b000};
      end
      OP_XOR: begin
        r8 = a8 ^ b8;
        nf = {r8 == '0, 3'b000};
      end
      OP_INC: begin
        r8 = a8 + 8'd1;
        nf = {r8 == '0, 1'b0, a8[3:0] == 4'hF, cin};
      end
      OP_DEC: begin
        r8 = a8 - 8'd1;
        nf = {r8 == '0, 1'b1, a8[3:0] == 4'h0, cin};
      end
      OP_CPL: begin
        r8 = ~a8;
        nf = {req.flags[FLAG_Z], 1'b1, 1'b1, cin};
      end
      OP_CCF: begin
        r8 = a8;
        nf = {req.flags[FLAG_Z], 1'b0, 1'b0, ~cin};
      end
      OP_RRA: begin
        r8 = {cin, a8[BYTE_W-1:1]};
        nf = {3'b000, a8[0]};
      end
      OP_RR: begin
        r8 = {cin, a8[BYTE_W-1:1]};
        nf = {r8 == '0, 2'b00, a8[0]};
      end
      OP_SRL: begin
        r8 = {1'b0, a8[BYTE_W-1:1]};
        nf = {r8 == '0, 2'b00, a8[0]};
      end
      OP_SWAP: begin
        r8 = {a8[3:0], a8[7:4]};
        nf = {r8 == '0, 3'b000};
      end
      OP_ADD16: begin
        use8 = 1'b0;
        r16  = sum16[WORD_W-1:0];
        nf   = {req.flags[FLAG_Z], 1'b0, sum12[12], sum16[WORD_W]};
      end
      OP_ADD_SP_E8: begin
        use8 = 1'b0;
        r16  = req.a + {{BYTE_W{b8[BYTE_W-1]}}, b8};
        nf   = {2'b00, sum4[4], sum8[BYTE_W]};
      end
      OP_INC16: begin
        use8 = 1'b0;
        r16  = req.a + 16'd1;
      end
      OP_DEC16: begin
        use8 = 1'b0;
        r16  = req.a - 16'd1;
      end
      default: begin
        use8 = 1'b0;
      end
    endcase
  end

  assign rsp.result = use8 ? {{(WORD_W-BYTE_W){1'b0}}, r8} : r16;
  assign rsp.flags  = nf;

endmodule

// File: hw/rtl/ebcalu_out_stage.sv
module ebcalu_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  output logic                 up_stall,
  input  ebcalu_pkg::alu_rsp_t up_rsp,
  input  logic                 dn_stall,
  output logic                 dn_valid,
  output ebcalu_pkg::alu_rsp_t dn_rsp
);
  import ebcalu_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  alu_rsp_t rsp_r;
  logic     load;

  assign up_stall  = valid_r && dn_stall;
  assign load      = up_valid && !up_stall;
  assign valid_nxt = load || (valid_r && dn_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp_r <= up_rsp;
    end
  end

  assign dn_valid = valid_r;
  assign dn_rsp   = rsp_r;

endmodule

// File: hw/rtl/eight_bit_cpu_alu_with_flags_unit.sv
// channel | valid     | stall     | payload
// --------+-----------+-----------+--------------------------------------------
// input   | in_valid  | in_stall  | in_kind, in_operand_a, in_operand_b, in_flags_in
// result  | out_valid | out_stall | out_result, out_flags_out
//
// Items pass both registers in turn; one item per cycle while out_stall is low.
// The ALU sits alone between the input register and the result register.
// Reset (rst_n low, synchronous) empties both registers.
// A held result stalls the input register; in_stall rises only when both
// registers are full and out_stall is high.
`include "eight_bit_cpu_alu_with_flags_unit_macros.svh"

module eight_bit_cpu_alu_with_flags_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [ebcalu_pkg::KIND_W-1:0]    in_kind,
  input  logic [ebcalu_pkg::WORD_W-1:0]    in_operand_a,
  input  logic [ebcalu_pkg::WORD_W-1:0]    in_operand_b,
  input  logic [ebcalu_pkg::FLAGS_W-1:0]   in_flags_in,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [ebcalu_pkg::WORD_W-1:0]    out_result,
  output logic [ebcalu_pkg::FLAGS_W-1:0]   out_flags_out
);
  import ebcalu_pkg::*;

  alu_req_t  in_req;
  alu_req_t  s1_req;
  alu_rsp_t  s1_rsp;
  alu_rsp_t  out_rsp;
  stage_hs_t s1_hs;

  assign in_req = '{kind: in_kind, a: in_operand_a, b: in_operand_b, flags: in_flags_in};

  ebcalu_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_stall (in_stall),
    .up_req   (in_req),
    .dn_stall (s1_hs.stall),
    .dn_valid (s1_hs.valid),
    .dn_req   (s1_req)
  );

  ebcalu_core u_core (
    .req (s1_req),
    .rsp (s1_rsp)
  );

  ebcalu_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_hs.valid),
    .up_stall (s1_hs.stall),
    .up_rsp   (s1_rsp),
    .dn_stall (out_stall),
    .dn_valid (out_valid),
    .dn_rsp   (out_rsp)
  );

  assign out_result    = out_rsp.result;
  assign out_flags_out = out_rsp.flags;

  `EBCALU_ASSERT_IMP(a_full_stall, s1_hs.valid && out_valid && out_stall, in_stall)
  `EBCALU_ASSERT_IMP(a_no_false_stall, !s1_hs.valid || !out_stall, !in_stall)
  `EBCALU_ASSERT_NXT(a_in_lands, in_valid && !in_stall, s1_hs.valid)
  `EBCALU_ASSERT_NXT(a_s1_moves, s1_hs.valid && !s1_hs.stall, out_valid)
  `EBCALU_ASSERT_NXT(a_cp_keeps_a, s1_hs.valid && !s1_hs.stall && (s1_req.kind == OP_CP),
                     out_result == $past(s1_req.a))

endmodule

// File: verif/tb.sv
import ebcalu_pkg::*;

class alu_checker;
  alu_rsp_t pending_outcomes[$];
  int unsigned errors;

  function new();
    errors = 0;
  endfunction

  function logic [FLAGS_W-1:0] pack_flags(logic z, logic n, logic h, logic c);
    logic [FLAGS_W-1:0] v;
    v = '0;
    v[FLAG_Z] = z;
    v[FLAG_N] = n;
    v[FLAG_H] = h;
    v[FLAG_C] = c;
    return v;
  endfunction

  function alu_rsp_t predict_alu_outcome(logic [KIND_W-1:0] kind, logic [WORD_W-1:0] a16,
                                         logic [WORD_W-1:0] b16, logic [FLAGS_W-1:0] f);
    logic [BYTE_W-1:0] a;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] r8;
    logic [BYTE_W:0] s9;
    logic [4:0] s5;
    logic [12:0] s13;
    logic [WORD_W:0] s17;
    logic cin;
    alu_rsp_t o;
    a = a16[BYTE_W-1:0];
    b = b16[BYTE_W-1:0];
    cin = f[FLAG_C];
    o.result = a16;
    o.flags = f;
    case (kind)
      OP_ADD, OP_ADC: begin
        if (kind == OP_ADD) cin = 1'b0;
        s9 = {1'b0, a} + {1'b0, b} + {8'h00, cin};
        s5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, cin};
        o.result = {8'h00, s9[7:0]};
        o.flags = pack_flags(s9[7:0] == 8'h00, 1'b0, s5[4], s9[8]);
      end
      OP_SUB, OP_CP: begin
        r8 = a - b;
        o.flags = pack_flags(r8 == 8'h00, 1'b1, a[3:0] < b[3:0], a < b);
        // compare leaves the whole 16-bit operand on the result
        o.result = (kind == OP_SUB) ? {8'h00, r8} : a16;
      end
      OP_AND: begin
        r8 = a & b;
        o.result = {8'h00, r8};
        o.flags = pack_flags(r8 == 8'h00, 1'b0, 1'b1, 1'b0);
      end
      OP_OR: begin
        r8 = a | b;
        o.result = {8'h00, r8};
        o.flags = pack_flags(r8 == 8'h00, 1'b0, 1'b0, 1'b0);
      end
      OP_XOR: begin
        r8 = a ^ b;
        o.result = {8'h00, r8};
        o.flags = pack_flags(r8 == 8'h00, 1'b0, 1'b0, 1'b0);
      end
      OP_INC: begin
        r8 = a + 8'h01;
        o.result = {8'h00, r8};
        o.flags = pack_flags(r8 == 8'h00, 1'b0, a[3:0] == 4'hF, cin);
      end
      OP_DEC: begin
        r8 = a - 8'h01;
        o.result = {8'h00, r8};
        o.flags = pack_flags(r8 == 8'h00, 1'b1, a[3:0] == 4'h0, cin);
      end
      OP_CPL: begin
        o.result = {8'h00, ~a};
        o.flags = pack_flags(f[FLAG_Z], 1'b1, 1'b1, cin);
      end
      OP_CCF: begin
        o.result = {8'h00, a};
        o.flags = pack_flags(f[FLAG_Z], 1'b0, 1'b0, ~cin);
      end
      OP_RRA, OP_RR: begin
        r8 = {cin, a[7:1]};
        o.result = {8'h00, r8};
        // accumulator form always clears Z
        o.flags = pack_flags(kind == OP_RR && r8 == 8'h00, 1'b0, 1'b0, a[0]);
      end
      OP_SRL: begin
        r8 = {1'b0, a[7:1]};
        o.result = {8'h00, r8};
        o.flags = pack_flags(r8 == 8'h00, 1'b0, 1'b0, a[0]);
      end
      OP_SWAP: begin
        r8 = {a[3:0], a[7:4]};
        o.result = {8'h00, r8};
        o.flags = pack_flags(r8 == 8'h00, 1'b0, 1'b0, 1'b0);
      end
      OP_ADD16: begin
        s17 = {1'b0, a16} + {1'b0, b16};
        s13 = {1'b0, a16[11:0]} + {1'b0, b16[11:0]};
        o.result = s17[WORD_W-1:0];
        o.flags = pack_flags(f[FLAG_Z], 1'b0, s13[12], s17[WORD_W]);
      end
      OP_ADD_SP_E8: begin
        // H and C come from the unsigned low-byte sum
        s9 = {1'b0, a} + {1'b0, b};
        s5 = {1'b0, a[3:0]} + {1'b0, b[3:0]};
        o.result = a16 + {{8{b[7]}}, b};
        o.flags = pack_flags(1'b0, 1'b0, s5[4], s9[8]);
      end
      OP_INC16: o.result = a16 + 16'h0001;
      OP_DEC16: o.result = a16 - 16'h0001;
      default: ;
    endcase
    return o;
  endfunction

  function void note_transfer(logic [KIND_W-1:0] kind, logic [WORD_W-1:0] a,
                              logic [WORD_W-1:0] b, logic [FLAGS_W-1:0] f);
    pending_outcomes.push_back(predict_alu_outcome(kind, a, b, f));
  endfunction

  function void check_result(logic [WORD_W-1:0] res, logic [FLAGS_W-1:0] flg);
    alu_rsp_t want;
    if (pending_outcomes.size() == 0) begin
      errors++;
      $error("unexpected result transfer: result %h flags_out %h", res, flg);
      return;
    end
    want = pending_outcomes.pop_front();
    if (res !== want.result) begin
      errors++;
      $error("result: expected %h, actual %h", want.result, res);
    end
    if (flg !== want.flags) begin
      errors++;
      $error("flags_out: expected %h, actual %h", want.flags, flg);
    end
  endfunction

  function int unsigned outstanding();
    return pending_outcomes.size();
  endfunction
endclass

module tb;
  localparam logic [KIND_W-1:0] KIND_UNUSED_LO  = 5'd19;
  localparam logic [KIND_W-1:0] KIND_UNUSED_TOP = 5'd31;
  localparam int unsigned RANDOM_ITEMS = 1300;
  localparam int unsigned LONG_HOLD = 160;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [KIND_W-1:0]   in_kind;
  logic [WORD_W-1:0]   in_operand_a;
  logic [WORD_W-1:0]   in_operand_b;
  logic [FLAGS_W-1:0]  in_flags_in;
  logic                out_valid;
  logic                out_stall;
  logic [WORD_W-1:0]   out_result;
  logic [FLAGS_W-1:0]  out_flags_out;

  alu_checker board = new();

  eight_bit_cpu_alu_with_flags_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_operand_a  (in_operand_a),
    .in_operand_b  (in_operand_b),
    .in_flags_in   (in_flags_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_result    (out_result),
    .out_flags_out (out_flags_out)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // transfers are sampled before this edge's updates land
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        board.note_transfer(in_kind, in_operand_a, in_operand_b, in_flags_in);
      if (out_valid && !out_stall)
        board.check_result(out_result, out_flags_out);
    end
  end

  function automatic logic [WORD_W-1:0] pick_operand();
    logic [WORD_W-1:0] v;
    v = WORD_W'($urandom);
    case ($urandom_range(0, 9))
      0: v = 16'h0000;
      1: v = 16'hFFFF;
      2: v[7:0] = 8'hFF;
      3: v[7:0] = 8'h00;
      4: v[3:0] = 4'hF;
      5: v[7:0] = 8'h80;
      6: v[11:0] = 12'hFFF;
      default: ;
    endcase
    return v;
  endfunction

  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [WORD_W-1:0] a,
                           input logic [WORD_W-1:0] b, input logic [FLAGS_W-1:0] f,
                           input int unsigned gap);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= kind;
    in_operand_a <= a;
    in_operand_b <= b;
    in_flags_in  <= f;
    do @(posedge clk); while (in_stall);
  endtask

  // result side: random stalls, quiet stretches, and two long hold-offs
  initial begin
    int unsigned hold;
    int unsigned taken;
    taken = 0;
    out_stall <= 1'b0;
    forever begin
      if (taken == 400 || taken == 1000) hold = LONG_HOLD;
      else if ((taken / 60) % 3 == 1) hold = 0;
      else hold = $urandom_range(0, 11);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  initial begin
    int unsigned idx;
    logic [KIND_W-1:0] k;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_kind      <= '0;
    in_operand_a <= '0;
    in_operand_b <= '0;
    in_flags_in  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed corners, one or more per operation
    send_item(OP_ADD,       16'h000F, 16'h0001, 4'h0, $urandom_range(0, 11));
    send_item(OP_ADD,       16'hABFF, 16'hFF01, 4'hF, $urandom_range(0, 11));
    send_item(OP_ADC,       16'h000F, 16'h0000, 4'h1, $urandom_range(0, 11));
    send_item(OP_ADC,       16'hFFFF, 16'hFFFF, 4'hF, $urandom_range(0, 11));
    send_item(OP_SUB,       16'h0010, 16'h0001, 4'h0, $urandom_range(0, 11));
    send_item(OP_SUB,       16'hFF00, 16'h0001, 4'hF, $urandom_range(0, 11));
    send_item(OP_CP,        16'h1234, 16'hFF34, 4'h0, $urandom_range(0, 11));
    send_item(OP_AND,       16'hFFF0, 16'hFF0F, 4'hF, $urandom_range(0, 11));
    send_item(OP_OR,        16'hFF00, 16'hFF00, 4'hF, $urandom_range(0, 11));
    send_item(OP_XOR,       16'h00FF, 16'hFFFF, 4'h0, $urandom_range(0, 11));
    send_item(OP_INC,       16'hFFFF, 16'h0000, 4'h1, $urandom_range(0, 11));
    send_item(OP_DEC,       16'h0010, 16'h0000, 4'h0, $urandom_range(0, 11));
    send_item(OP_DEC,       16'hFF01, 16'h0000, 4'hE, $urandom_range(0, 11));
    send_item(OP_CPL,       16'hFF00, 16'h0000, 4'hF, $urandom_range(0, 11));
    send_item(OP_CCF,       16'hFFA5, 16'h0000, 4'h9, $urandom_range(0, 11));
    send_item(OP_RRA,       16'h0001, 16'h0000, 4'h0, $urandom_range(0, 11));
    send_item(OP_RRA,       16'hFF01, 16'h0000, 4'hF, $urandom_range(0, 11));
    send_item(OP_RR,        16'h0001, 16'h0000, 4'h0, $urandom_range(0, 11));
    send_item(OP_SRL,       16'hFF01, 16'h0000, 4'hF, $urandom_range(0, 11));
    send_item(OP_SWAP,      16'hFFF0, 16'h0000, 4'hF, $urandom_range(0, 11));
    send_item(OP_ADD16,     16'hFFFF, 16'h0001, 4'h8, $urandom_range(0, 11));
    send_item(OP_ADD_SP_E8, 16'hFFF8, 16'hFF08, 4'hF, $urandom_range(0, 11));
    send_item(OP_ADD_SP_E8, 16'h0000, 16'h0080, 4'h0, $urandom_range(0, 11));
    send_item(OP_INC16,     16'hFFFF, 16'h0000, 4'hF, $urandom_range(0, 11));
    send_item(OP_DEC16,     16'h0000, 16'hFFFF, 4'h0, 0);
    send_item(KIND_UNUSED_TOP, 16'hFFFF, 16'hFFFF, 4'hF, 0);

    for (idx = 0; idx < RANDOM_ITEMS; idx++) begin
      if ($urandom_range(0, 9) == 0)
        k = KIND_W'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_TOP));
      else k = KIND_W'($urandom_range(OP_ADD, OP_DEC16));
      send_item(k, pick_operand(), pick_operand(), FLAGS_W'($urandom_range(0, 15)),
                ((idx / 50) % 3 == 2) ? 0 : $urandom_range(0, 11));
    end
    in_valid <= 1'b0;

    while (board.outstanding() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("DONE: errors detected");
    $finish;
  end
endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/ebcalu_pkg.sv
hw/rtl/ebcalu_in_stage.sv
hw/rtl/ebcalu_core.sv
hw/rtl/ebcalu_out_stage.sv
hw/rtl/eight_bit_cpu_alu_with_flags_unit.sv
verif/tb.sv
